// ===== sv/fgcc_pkg.sv =====
package fgcc_pkg;

  localparam int SUCC_W           = 11;
  localparam int COUNT_W          = 11;
  localparam int STATUS_W         = 2;
  localparam int MAX_VERTICES_DEF = 1024;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_COUNT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_CLEAR,
    ST_WALK_REQ,
    ST_WALK_CHK,
    ST_EMIT
  } state_t;

endpackage

// ===== sv/fgcc_if.sv =====
interface fgcc_in_if;
  logic                       valid;
  logic                       ready;
  logic [fgcc_pkg::SUCC_W-1:0] successor;
  logic                       last;

  modport source (output valid, output successor, output last, input ready);
  modport sink   (input valid, input successor, input last, output ready);
endinterface

interface fgcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [fgcc_pkg::COUNT_W-1:0]  cycle_count;
  logic [fgcc_pkg::STATUS_W-1:0] status;

  modport source (output valid, output cycle_count, output status, input ready);
  modport sink   (input valid, input cycle_count, input status, output ready);
endinterface

// ===== sv/fgcc_ram.sv =====
module fgcc_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/functional_graph_cycle_counter.sv =====
// Channel  Direction  Payload                         Transaction when
// in_ch    input      successor[10:0], last           valid && ready
// out_ch   output     cycle_count[10:0], status[1:0]  valid && ready
//
// Loading accepts the vertices of a graph in order. After the last vertex, a
// check state follows and, on an error, goes straight to emit; else the clear
// state zeroes the label entry of every loaded vertex. Each walk step has a
// request state (label read) and a check state (check and write): one step per
// labelled vertex and one closing step per start vertex. An emit state ends it.
// The registered read of the label memory sets this split of each walk step.
// Reset is synchronous and active low. The result register frees the input
// side, so loading of the next graph overlaps a stalled result.
module functional_graph_cycle_counter #(
  parameter int MAX_VERTICES = fgcc_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fgcc_in_if.sink     in_ch,
  fgcc_out_if.source  out_ch
);
  import fgcc_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int LW = VW + 1;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        vtot_r, vtot_nxt;
  logic [VW-1:0]        maxs_r, maxs_nxt;
  logic                 err_range_r, err_range_nxt;
  logic                 err_count_r, err_count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [VW-1:0]        start_r, start_nxt;
  logic [VW-1:0]        vert_r, vert_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  status_t              status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;
  status_t              out_status_r, out_status_nxt;

  logic                 s_we;
  logic [VW-1:0]        s_waddr, s_raddr, s_wdata, s_rdata;
  logic                 l_we;
  logic [VW-1:0]        l_waddr, l_raddr;
  logic [LW-1:0]        l_wdata, l_rdata;

  logic                 in_fire, out_free, table_full, succ_bad, range_hit;
  logic                 lbl_valid, vert_in, walk_end, last_start, clear_done;
  logic [VW-1:0]        succ_zb, lbl_start;

  fgcc_ram #(.DATA_W(VW), .DEPTH(MAX_VERTICES), .ADDR_W(VW)) u_succ_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  fgcc_ram #(.DATA_W(LW), .DEPTH(MAX_VERTICES), .ADDR_W(VW)) u_label_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  assign in_ch.ready        = (state_r == ST_LOAD);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.cycle_count = out_count_r;
  assign out_ch.status      = out_status_r;

  assign table_full = (vtot_r == CW'(MAX_VERTICES));
  assign succ_bad   = (in_ch.successor == '0) ||
                      (32'(in_ch.successor) > 32'(MAX_VERTICES));
  assign succ_zb    = succ_bad ? '0 : VW'(in_ch.successor - SUCC_W'(1));
  assign range_hit  = (CW'(maxs_r) >= vtot_r);
  assign lbl_valid  = l_rdata[VW];
  assign lbl_start  = l_rdata[VW-1:0];
  assign vert_in    = (CW'(vert_r) < vtot_r);
  assign walk_end   = !vert_in || lbl_valid;
  assign last_start = ((CW'(start_r) + CW'(1)) == vtot_r);
  assign clear_done = ((idx_r + CW'(1)) == vtot_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire && in_ch.last) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (err_count_r || err_range_r || range_hit) state_nxt = ST_EMIT;
        else state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (clear_done) state_nxt = ST_WALK_REQ;
      end
      ST_WALK_REQ: begin
        state_nxt = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (walk_end && last_start) state_nxt = ST_EMIT;
        else state_nxt = ST_WALK_REQ;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    vtot_nxt       = vtot_r;
    maxs_nxt       = maxs_r;
    err_range_nxt  = err_range_r;
    err_count_nxt  = err_count_r;
    idx_nxt        = idx_r;
    start_nxt      = start_r;
    vert_nxt       = vert_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    s_we           = 1'b0;
    s_waddr        = vtot_r[VW-1:0];
    s_wdata        = succ_zb;
    s_raddr        = vert_r;
    l_we           = 1'b0;
    l_waddr        = vert_r;
    l_wdata        = {1'b1, start_r};
    l_raddr        = vert_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (table_full) begin
            err_count_nxt = 1'b1;
          end else begin
            s_we = 1'b1;
            if (succ_bad) err_range_nxt = 1'b1;
            if (succ_zb > maxs_r) maxs_nxt = succ_zb;
            vtot_nxt = vtot_r + CW'(1);
          end
        end
      end
      ST_CHECK: begin
        idx_nxt   = '0;
        start_nxt = '0;
        vert_nxt  = '0;
        count_nxt = '0;
        if (err_count_r) status_nxt = STATUS_COUNT;
        else if (err_range_r || range_hit) status_nxt = STATUS_RANGE;
        else status_nxt = STATUS_OK;
      end
      ST_CLEAR: begin
        l_we    = 1'b1;
        l_waddr = idx_r[VW-1:0];
        l_wdata = '0;
        idx_nxt = idx_r + CW'(1);
      end
      ST_WALK_CHK: begin
        if (walk_end) begin
          if (vert_in && lbl_valid && (lbl_start == start_r)) begin
            count_nxt = count_r + CW'(1);
          end
          start_nxt = start_r + VW'(1);
          vert_nxt  = start_r + VW'(1);
        end else begin
          l_we     = 1'b1;
          vert_nxt = s_rdata;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = COUNT_W'(count_r);
          out_status_nxt = status_r;
          vtot_nxt       = '0;
          maxs_nxt       = '0;
          err_range_nxt  = 1'b0;
          err_count_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      vtot_r      <= '0;
      maxs_r      <= '0;
      err_range_r <= 1'b0;
      err_count_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vtot_r      <= vtot_nxt;
      maxs_r      <= maxs_nxt;
      err_range_r <= err_range_nxt;
      err_count_r <= err_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    start_r      <= start_nxt;
    vert_r       <= vert_nxt;
    count_r      <= count_nxt;
    status_r     <= status_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside the emit state");

  a_error_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STATUS_OK)) |-> (out_count_r == '0))
    else $error("error result carries a nonzero cycle count");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK_REQ) |-> vert_in)
    else $error("walk left the loaded vertex range");

  a_label_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    l_we |-> ((state_r == ST_CLEAR) || (state_r == ST_WALK_CHK)))
    else $error("label memory written outside clear or walk");

endmodule

// ===== bench/cycle_count_checker.sv =====
`timescale 1ns / 1ps

module cycle_count_checker #(
  parameter int MAX_VERTICES = fgcc_pkg::MAX_VERTICES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  fgcc_in_if   in_mon,
  fgcc_out_if  out_mon,
  output int   mismatches,
  output int   awaiting
);
  import fgcc_pkg::*;

  typedef struct packed {
    logic [COUNT_W-1:0] cycle_count;
    status_t            status;
  } graph_result_t;

  graph_result_t expected_counts[$];

  int unsigned succ_mem[MAX_VERTICES];
  int unsigned owner_of[MAX_VERTICES];
  bit          seen[MAX_VERTICES];
  int unsigned loaded       = 0;
  bit          range_err    = 1'b0;
  bit          overflow_err = 1'b0;
  int          fail_count   = 0;
  int          waiting_count = 0;

  assign mismatches = fail_count;
  assign awaiting   = waiting_count;

  function automatic int unsigned count_graph_cycles(int unsigned n);
    int unsigned cycles;
    int unsigned v;
    cycles = 0;
    for (int unsigned i = 0; i < n; i++) seen[i] = 1'b0;
    for (int unsigned s = 0; s < n; s++) begin
      if (!seen[s]) begin
        v = s;
        while (v < n && !seen[v]) begin
          seen[v]     = 1'b1;
          owner_of[v] = s;
          v           = succ_mem[v];
        end
        if (v < n && owner_of[v] == s) cycles++;
      end
    end
    return cycles;
  endfunction

  function automatic void load_vertex(logic [SUCC_W-1:0] succ, logic is_last);
    graph_result_t res;
    if (loaded >= MAX_VERTICES) begin
      overflow_err = 1'b1;
    end else begin
      if (succ == 0 || succ > MAX_VERTICES) begin
        range_err        = 1'b1;
        succ_mem[loaded] = 0;
      end else begin
        succ_mem[loaded] = succ - 1;
      end
      loaded++;
    end
    if (is_last) begin
      // Successors past the end of the graph are only known once it is complete.
      for (int unsigned i = 0; i < loaded; i++) begin
        if (succ_mem[i] >= loaded) range_err = 1'b1;
      end
      res.cycle_count = '0;
      if (overflow_err) begin
        res.status = STATUS_COUNT;
      end else if (range_err) begin
        res.status = STATUS_RANGE;
      end else begin
        res.status      = STATUS_OK;
        res.cycle_count = COUNT_W'(count_graph_cycles(loaded));
      end
      expected_counts = {expected_counts, res};
      loaded       = 0;
      range_err    = 1'b0;
      overflow_err = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    graph_result_t want;
    if (!rst_n) begin
      expected_counts.delete();
      loaded       = 0;
      range_err    = 1'b0;
      overflow_err = 1'b0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_counts.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transaction: cycle_count %0d status %0d",
                   $time, out_mon.cycle_count, out_mon.status);
        end else begin
          want = expected_counts.pop_front();
          if (out_mon.cycle_count !== want.cycle_count) begin
            fail_count++;
            $display("%0t: cycle_count mismatch: expected %0d, actual %0d",
                     $time, want.cycle_count, out_mon.cycle_count);
          end
          if (out_mon.status !== want.status) begin
            fail_count++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_mon.status);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) load_vertex(in_mon.successor, in_mon.last);
    end
    waiting_count = expected_counts.size();
  end

endmodule

// ===== bench/tb_functional_graph_cycle_counter.sv =====
`timescale 1ns / 1ps

module tb_functional_graph_cycle_counter;
  import fgcc_pkg::*;

  localparam int MAXV         = MAX_VERTICES_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 64;

  typedef enum int {
    SHAPE_MAP,
    SHAPE_PERM,
    SHAPE_RING,
    SHAPE_SELF,
    SHAPE_BAD
  } shape_t;

  typedef int vertex_list_t[$];

  logic        clk;
  logic        rst_n;
  int          mismatches;
  int          awaiting;
  int unsigned cycle_no   = 0;
  bit          src_burst  = 1'b0;
  bit          sink_burst = 1'b0;
  int          stall_left = 0;

  fgcc_in_if  in_ch ();
  fgcc_out_if out_ch ();

  functional_graph_cycle_counter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cycle_count_checker #(
    .MAX_VERTICES (MAXV)
  ) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic vertex_list_t make_graph(int n, shape_t shape);
    vertex_list_t g;
    int           perm[$];
    int           j, t, hits, pos, bad;
    for (int i = 0; i < n; i++) begin
      g    = {g, 0};
      perm = {perm, i + 1};
    end
    for (int i = n - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    case (shape)
      SHAPE_PERM: begin
        for (int i = 0; i < n; i++) g[i] = perm[i];
      end
      SHAPE_RING: begin
        for (int k = 0; k < n; k++) g[perm[k] - 1] = perm[(k + 1) % n];
      end
      SHAPE_SELF: begin
        for (int i = 0; i < n; i++) g[i] = $urandom_range(0, 1) ? i + 1 : $urandom_range(1, n);
      end
      default: begin
        for (int i = 0; i < n; i++) g[i] = $urandom_range(1, n);
      end
    endcase
    if (shape == SHAPE_BAD) begin
      hits = $urandom_range(1, 2);
      for (int h = 0; h < hits; h++) begin
        pos = $urandom_range(0, n - 1);
        case ($urandom_range(0, 2))
          0:       bad = 0;
          1:       bad = (n < MAXV) ? $urandom_range(n + 1, MAXV) : 0;
          default: bad = $urandom_range(MAXV + 1, 2047);
        endcase
        g[pos] = bad;
      end
    end
    return g;
  endfunction

  task automatic send_item(int succ, bit is_last);
    int gap;
    gap = src_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.successor = SUCC_W'(succ);
    in_ch.last      = is_last;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_graph(input vertex_list_t g);
    foreach (g[i]) send_item(g[i], i == g.size() - 1);
  endtask

  task automatic send_overflow_graph();
    vertex_list_t g;
    g = make_graph(MAXV + $urandom_range(1, 3), SHAPE_MAP);
    g[$urandom_range(0, MAXV - 1)] = MAXV;
    if ($urandom_range(0, 1) == 1) g[$urandom_range(0, MAXV - 1)] = 0;
    send_graph(g);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 149) == 0) sink_burst = !sink_burst;
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (!sink_burst && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    vertex_list_t g;
    int           n, r, over_at, small_items;
    bit           over_done;
    shape_t       shape;
    in_ch.valid     = 1'b0;
    in_ch.successor = '0;
    in_ch.last      = 1'b0;
    rst_n           = 1'b0;
    small_items     = 0;
    over_done       = 1'b0;
    over_at         = $urandom_range(0, 400);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_graph({1});
    send_graph({0});
    send_graph({2047});
    send_graph({2, 1});
    send_graph({1, 1, 2});
    send_graph({2, 3, 1});
    send_graph({3, 1});
    send_graph({1, 2, 3});
    send_graph({2, 1, 4, 1025});

    while (small_items < RANDOM_ITEMS) begin
      src_burst = ($urandom_range(0, 4) == 0);
      if (!over_done && small_items >= over_at) begin
        send_overflow_graph();
        over_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 12);
      else if (r < 95) n = $urandom_range(13, 64);
      else n = $urandom_range(65, 256);
      r = $urandom_range(0, 99);
      if (r < 35) shape = SHAPE_MAP;
      else if (r < 50) shape = SHAPE_PERM;
      else if (r < 62) shape = SHAPE_RING;
      else if (r < 75) shape = SHAPE_SELF;
      else shape = SHAPE_BAD;
      g = make_graph(n, shape);
      send_graph(g);
      small_items += n;
    end
    if (!over_done) begin
      send_overflow_graph();
      over_done = 1'b1;
    end
    in_ch.valid = 1'b0;

    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== functional_graph_cycle_counter.f =====
sv/fgcc_pkg.sv
sv/fgcc_if.sv
sv/fgcc_ram.sv
sv/functional_graph_cycle_counter.sv
bench/cycle_count_checker.sv
bench/tb_functional_graph_cycle_counter.sv
